>>> rtl/core/simd8x16_pkg.sv
// simd8x16_pkg: action codes and lane constants for the 16-lane int8 vector ALU.
// No dependencies; imported by simd_int8x16_alu_top.

package simd8x16_pkg;

   localparam int ACT_W      = 5;
   localparam int LANE_W     = 8;
   localparam int MAX_LANES  = 16;
   localparam int HALF_LANES = 8;
   localparam int HALF_W     = HALF_LANES * LANE_W;
   localparam int VEC_W      = MAX_LANES * LANE_W;

   localparam logic [LANE_W-1:0] SAT_MAX   = 8'h7F;
   localparam logic [LANE_W-1:0] SAT_MIN   = 8'h80;
   localparam logic [LANE_W-1:0] MASK_ON   = 8'hFF;
   localparam logic [LANE_W-1:0] MASK_OFF  = 8'h00;
   localparam logic [LANE_W-1:0] SEL_TRUE  = 8'h01;
   localparam logic [3:0]        MAX_SHIFT = 4'd8;

   typedef enum logic [ACT_W-1:0] {
      ACT_BUILD  = 5'd0,
      ACT_SPLAT  = 5'd1,
      ACT_NEG    = 5'd2,
      ACT_ADD    = 5'd3,
      ACT_SUB    = 5'd4,
      ACT_MUL    = 5'd5,
      ACT_ADDSAT = 5'd6,
      ACT_SUBSAT = 5'd7,
      ACT_MIN    = 5'd8,
      ACT_MAX    = 5'd9,
      ACT_LT     = 5'd10,
      ACT_LE     = 5'd11,
      ACT_EQ     = 5'd12,
      ACT_NE     = 5'd13,
      ACT_GT     = 5'd14,
      ACT_GE     = 5'd15,
      ACT_SHL    = 5'd16,
      ACT_SHR    = 5'd17,
      ACT_SELECT = 5'd18
   } action_type;

endpackage

>>> rtl/core/simd_int8x16_alu_top.sv
// simd_int8x16_alu_top: 16-lane signed 8-bit vector ALU, input register,
// lane logic, result register. Depends on simd8x16_pkg.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | req_valid/req_ready, req_action, a/b/c  | in
//          | halves, req_scalar                      |
//  result  | rsp_valid/rsp_ready, rsp_result_low/high| out
//
// The accepting edge loads a word into the input register; its lane results load
// into the result register once that is empty or being drained, and rsp_valid
// then rises. A new word is accepted every cycle unless the result register
// stalls; throughput is set by the single-pass lane datapath.
// Reset clears both valid flags; payload registers hold whatever they had.
// A stalled result holds in place; the input register advances into the
// result register only when the result register is empty or being drained.

module simd_int8x16_alu_top #(
   parameter int LANES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [simd8x16_pkg::ACT_W-1:0]   req_action,
   input  logic [simd8x16_pkg::HALF_W-1:0]  req_a_low,
   input  logic [simd8x16_pkg::HALF_W-1:0]  req_a_high,
   input  logic [simd8x16_pkg::HALF_W-1:0]  req_b_low,
   input  logic [simd8x16_pkg::HALF_W-1:0]  req_b_high,
   input  logic [simd8x16_pkg::HALF_W-1:0]  req_c_low,
   input  logic [simd8x16_pkg::HALF_W-1:0]  req_c_high,
   input  logic signed [simd8x16_pkg::LANE_W-1:0] req_scalar,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [simd8x16_pkg::HALF_W-1:0]  rsp_result_low,
   output logic [simd8x16_pkg::HALF_W-1:0]  rsp_result_high
);
   import simd8x16_pkg::*;

   // One lane of the ALU; every lane sees the same action and scalar.
   function automatic logic [LANE_W-1:0] lane_op(
      input logic [ACT_W-1:0]  act,
      input logic [LANE_W-1:0] ua,
      input logic [LANE_W-1:0] ub,
      input logic [LANE_W-1:0] uc,
      input logic [LANE_W-1:0] usc
   );
      logic signed [LANE_W-1:0] sa;
      logic signed [LANE_W-1:0] sb;
      logic signed [LANE_W-1:0] ssc;
      logic [3:0]               cnt;
      logic [LANE_W:0]          sum;
      logic [LANE_W:0]          dif;
      logic [LANE_W-1:0]        sum_sat;
      logic [LANE_W-1:0]        dif_sat;
      logic [LANE_W-1:0]        res;
      sa  = $signed(ua);
      sb  = $signed(ub);
      ssc = $signed(usc);
      // Clamp a count outside 0..8 to 8.
      if (ssc < 0 || ssc > $signed(8'(MAX_SHIFT)))
         cnt = MAX_SHIFT;
      else
         cnt = usc[3:0];
      // Nine-bit exact sum and difference; top two bits disagree on overflow.
      sum = {ua[LANE_W-1], ua} + {ub[LANE_W-1], ub};
      dif = {ua[LANE_W-1], ua} - {ub[LANE_W-1], ub};
      if (sum[LANE_W] != sum[LANE_W-1])
         sum_sat = sum[LANE_W] ? SAT_MIN : SAT_MAX;
      else
         sum_sat = sum[LANE_W-1:0];
      if (dif[LANE_W] != dif[LANE_W-1])
         dif_sat = dif[LANE_W] ? SAT_MIN : SAT_MAX;
      else
         dif_sat = dif[LANE_W-1:0];
      case (act)
         ACT_BUILD:  res = ua;
         ACT_SPLAT:  res = usc;
         ACT_NEG:    res = LANE_W'(0) - ua;
         ACT_ADD:    res = ua + ub;
         ACT_SUB:    res = ua - ub;
         ACT_MUL:    res = LANE_W'(ua * ub);
         ACT_ADDSAT: res = sum_sat;
         ACT_SUBSAT: res = dif_sat;
         ACT_MIN:    res = (sa < sb) ? ua : ub;
         ACT_MAX:    res = (sa > sb) ? ua : ub;
         ACT_LT:     res = (sa <  sb) ? MASK_ON : MASK_OFF;
         ACT_LE:     res = (sa <= sb) ? MASK_ON : MASK_OFF;
         ACT_EQ:     res = (sa == sb) ? MASK_ON : MASK_OFF;
         ACT_NE:     res = (sa != sb) ? MASK_ON : MASK_OFF;
         ACT_GT:     res = (sa >  sb) ? MASK_ON : MASK_OFF;
         ACT_GE:     res = (sa >= sb) ? MASK_ON : MASK_OFF;
         ACT_SHL:    res = ua << cnt;
         ACT_SHR:    res = LANE_W'(sa >>> cnt);
         ACT_SELECT: res = (ua == SEL_TRUE) ? ub : uc;
         default:    res = MASK_OFF;
      endcase
      return res;
   endfunction

   // Input register stage.
   logic               in_valid_ff;
   logic [ACT_W-1:0]   in_act_ff;
   logic [VEC_W-1:0]   in_a_ff;
   logic [VEC_W-1:0]   in_b_ff;
   logic [VEC_W-1:0]   in_c_ff;
   logic [LANE_W-1:0]  in_scalar_ff;

   // Result register stage.
   logic               out_valid_ff;
   logic [VEC_W-1:0]   out_res_ff;
   logic [VEC_W-1:0]   out_res_in;

   logic out_open;
   logic in_open;
   logic req_take;
   logic in_move;

   // Result register frees up when empty or drained this cycle.
   assign out_open  = !out_valid_ff || rsp_ready;
   assign in_open   = !in_valid_ff || out_open;
   assign req_ready = in_open;
   assign req_take  = req_valid && in_open;
   assign in_move   = in_valid_ff && out_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_open) begin
         in_valid_ff <= req_valid;
      end
      if (req_take) begin
         in_act_ff    <= req_action;
         in_a_ff      <= {req_a_high, req_a_low};
         in_b_ff      <= {req_b_high, req_b_low};
         in_c_ff      <= {req_c_high, req_c_low};
         in_scalar_ff <= req_scalar;
      end
   end

   // Lanes at LANES and above drop to zero.
   for (genvar k = 0; k < MAX_LANES; k++) begin : g_lane
      if (k < LANES) begin : g_live
         assign out_res_in[k*LANE_W +: LANE_W] =
            lane_op(in_act_ff, in_a_ff[k*LANE_W +: LANE_W],
                    in_b_ff[k*LANE_W +: LANE_W], in_c_ff[k*LANE_W +: LANE_W],
                    in_scalar_ff);
      end else begin : g_off
         assign out_res_in[k*LANE_W +: LANE_W] = MASK_OFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_open) begin
         out_valid_ff <= in_valid_ff;
      end
      if (in_move) begin
         out_res_ff <= out_res_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_low  = out_res_ff[HALF_W-1:0];
   assign rsp_result_high = out_res_ff[VEC_W-1:HALF_W];

endmodule

>>> rtl/core/simd8x16_chk.sv
// simd8x16_chk: port-level assertions for simd_int8x16_alu_top, plus the bind
// that attaches them. No package dependency.

module simd8x16_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_result_low,
   input logic [63:0] rsp_result_high
);

   // Words accepted but not yet delivered; the block holds at most two.
   logic [2:0] inflight_ff;
   logic [2:0] inflight_in;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_valid && req_ready)
         inflight_in = inflight_in + 3'd1;
      if (rsp_valid && rsp_ready)
         inflight_in = inflight_in - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= 3'd0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_result_low) && $stable(rsp_result_high))
      else $error("stalled result word changed");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 3'd2)
      else $error("more than two words in flight");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 3'd0)
      else $error("result word with nothing accepted");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      inflight_ff == 3'd0 |-> req_ready)
      else $error("empty block refuses a request");

endmodule

bind simd_int8x16_alu_top simd8x16_chk u_simd8x16_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_low  (rsp_result_low),
   .rsp_result_high (rsp_result_high)
);

>>> tb/sv/simd_int8x16_alu_top_test.sv
`timescale 1ns / 1ps
// simd_int8x16_alu_top_test: self-checking bench for the 16-lane int8 vector ALU.
// Drives directed and random words, predicts untyped results lane by lane, checks them in order.
// Depends on simd8x16_pkg and simd_int8x16_alu_top.

module simd_int8x16_alu_top_test;
   import simd8x16_pkg::*;

   localparam int TB_LANES    = 16;
   localparam int RANDOM_WORDS = 1350;
   localparam int LONG_HOLD   = 160;   // receiver hold-off that backs the pipe up
   localparam int DRAIN_TAIL  = 8;     // cycles after the last result, catches strays

   // Codes outside the action enum; the block must answer them with zero.
   localparam logic [ACT_W-1:0] ACT_UNKNOWN_FIRST = 5'd19;
   localparam logic [ACT_W-1:0] ACT_UNKNOWN_LAST  = 5'd31;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [VEC_W-1:0]  a;
      logic [VEC_W-1:0]  b;
      logic [VEC_W-1:0]  c;
      logic [LANE_W-1:0] scalar;
      bit                typed;        // typed_result holds the answer; skip the predictor
      logic [VEC_W-1:0]  typed_result;
   } vec_word_type;

   typedef struct packed {
      int unsigned      seq;
      logic [VEC_W-1:0] value;
   } pending_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [ACT_W-1:0]    req_action;
   logic [HALF_W-1:0]   req_a_low, req_a_high;
   logic [HALF_W-1:0]   req_b_low, req_b_high;
   logic [HALF_W-1:0]   req_c_low, req_c_high;
   logic signed [LANE_W-1:0] req_scalar;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [HALF_W-1:0]   rsp_result_low, rsp_result_high;

   vec_word_type       directed_rows[$];
   pending_result_type pending_results[$];
   int unsigned        words_accepted = 0;
   int unsigned        error_count    = 0;
   bit                 calm_mode      = 1'b0;   // no gaps on either side while set
   int                 rsp_hold_cycles = 0;     // request for a long receiver hold-off

   simd_int8x16_alu_top #(
      .LANES(TB_LANES)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_a_low       (req_a_low),
      .req_a_high      (req_a_high),
      .req_b_low       (req_b_low),
      .req_b_high      (req_b_high),
      .req_c_low       (req_c_low),
      .req_c_high      (req_c_high),
      .req_scalar      (req_scalar),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_low  (rsp_result_low),
      .rsp_result_high (rsp_result_high)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Lane predictor. Every lane is independent; the scalar is shared.
   // ---------------------------------------------------------------------
   function automatic logic [LANE_W-1:0] clamp_lane(int v);
      if (v > 127) return SAT_MAX;
      if (v < -128) return SAT_MIN;
      return v[LANE_W-1:0];
   endfunction

   function automatic logic [LANE_W-1:0] lane_result(logic [ACT_W-1:0] act,
         logic [LANE_W-1:0] ua, logic [LANE_W-1:0] ub, logic [LANE_W-1:0] uc,
         logic [LANE_W-1:0] usc);
      int sa, sb, ssc, cnt;
      logic [2*LANE_W-1:0] ext;
      logic [LANE_W-1:0]   r;
      sa  = int'($signed(ua));
      sb  = int'($signed(ub));
      ssc = int'($signed(usc));
      // A count below zero or past a full lane shifts everything out.
      cnt = (ssc < 0 || ssc > int'(MAX_SHIFT)) ? int'(MAX_SHIFT) : ssc;
      case (act)
         ACT_BUILD:  r = ua;
         ACT_SPLAT:  r = usc;
         ACT_NEG:    r = -ua;
         ACT_ADD:    r = ua + ub;
         ACT_SUB:    r = ua - ub;
         ACT_MUL:    r = ua * ub;
         ACT_ADDSAT: r = clamp_lane(sa + sb);
         ACT_SUBSAT: r = clamp_lane(sa - sb);
         ACT_MIN:    r = (sa < sb) ? ua : ub;
         ACT_MAX:    r = (sa > sb) ? ua : ub;
         ACT_LT:     r = (sa <  sb) ? MASK_ON : MASK_OFF;
         ACT_LE:     r = (sa <= sb) ? MASK_ON : MASK_OFF;
         ACT_EQ:     r = (sa == sb) ? MASK_ON : MASK_OFF;
         ACT_NE:     r = (sa != sb) ? MASK_ON : MASK_OFF;
         ACT_GT:     r = (sa >  sb) ? MASK_ON : MASK_OFF;
         ACT_GE:     r = (sa >= sb) ? MASK_ON : MASK_OFF;
         ACT_SHL:    r = ua << cnt;
         ACT_SHR: begin
            ext = {{LANE_W{ua[LANE_W-1]}}, ua};
            ext = ext >> cnt;
            r   = ext[LANE_W-1:0];
         end
         // Only an exact 0x01 mask lane takes the true vector.
         ACT_SELECT: r = (ua == SEL_TRUE) ? ub : uc;
         default:    r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [VEC_W-1:0] predict_vector(vec_word_type w);
      logic [VEC_W-1:0] v;
      v = '0;
      for (int k = 0; k < MAX_LANES; k++) begin
         if (k < TB_LANES)
            v[k*LANE_W +: LANE_W] = lane_result(w.action, w.a[k*LANE_W +: LANE_W],
                  w.b[k*LANE_W +: LANE_W], w.c[k*LANE_W +: LANE_W], w.scalar);
      end
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void add_row(logic [ACT_W-1:0] act, logic [VEC_W-1:0] a,
         logic [VEC_W-1:0] b, logic [VEC_W-1:0] c, logic [LANE_W-1:0] scalar,
         bit typed, logic [VEC_W-1:0] typed_result);
      vec_word_type w;
      w.action       = act;
      w.a            = a;
      w.b            = b;
      w.c            = c;
      w.scalar       = scalar;
      w.typed        = typed;
      w.typed_result = typed_result;
      directed_rows.push_back(w);
   endfunction

   // Mostly back-to-back, sometimes a few cycles, rarely a long gap.
   function automatic int pick_gap();
      int r;
      if (calm_mode) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   // Lanes lean toward the corner values so saturation, wrap and equal
   // compares come up often; the rest is plain random data.
   function automatic logic [VEC_W-1:0] random_vector(bit as_mask);
      logic [VEC_W-1:0] v;
      logic [LANE_W-1:0] lane;
      int mode;
      mode = $urandom_range(2);
      v = {$urandom, $urandom, $urandom, $urandom};
      if (mode != 0) begin
         for (int k = 0; k < MAX_LANES; k++) begin
            case ($urandom_range(5))
               0: lane = as_mask ? SEL_TRUE : SAT_MIN;
               1: lane = as_mask ? SEL_TRUE : SAT_MAX;
               2: lane = MASK_OFF;
               3: lane = as_mask ? MASK_ON : SEL_TRUE;
               4: lane = MASK_ON;
               default: lane = 8'($urandom);
            endcase
            v[k*LANE_W +: LANE_W] = lane;
         end
      end
      return v;
   endfunction

   function automatic vec_word_type random_word();
      vec_word_type w;
      if ($urandom_range(99) < 90)
         w.action = 5'($urandom_range(int'(ACT_SELECT)));
      else
         w.action = 5'($urandom_range(int'(ACT_UNKNOWN_LAST), int'(ACT_UNKNOWN_FIRST)));
      w.a = random_vector(w.action == ACT_SELECT && $urandom_range(9) < 7);
      w.b = random_vector(1'b0);
      w.c = random_vector(1'b0);
      // Half the counts sit around the legal shift window, edges included.
      if ($urandom_range(1))
         w.scalar = 8'($urandom_range(12)) - 8'd2;
      else
         w.scalar = 8'($urandom);
      w.typed        = 1'b0;
      w.typed_result = '0;
      return w;
   endfunction

   task automatic report_error(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Sender. Valid rises with its payload at a clock edge and stays up until
   // the word is taken; a word with no gap follows at the very edge of the
   // handshake, so valid is never dropped and raised in one step.
   // ---------------------------------------------------------------------
   task automatic offer(vec_word_type w);
      int gap;
      pending_result_type entry;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_action <= w.action;
      req_a_low  <= w.a[HALF_W-1:0];
      req_a_high <= w.a[VEC_W-1:HALF_W];
      req_b_low  <= w.b[HALF_W-1:0];
      req_b_high <= w.b[VEC_W-1:HALF_W];
      req_c_low  <= w.c[HALF_W-1:0];
      req_c_high <= w.c[VEC_W-1:HALF_W];
      req_scalar <= w.scalar;
      req_valid  <= 1'b1;
      // Values read at the edge are the ones the block saw: taken here.
      do @(posedge clock); while (req_ready !== 1'b1);
      entry.seq   = words_accepted;
      entry.value = w.typed ? w.typed_result : predict_vector(w);
      pending_results.push_back(entry);
      words_accepted++;
   endtask

   // Drop valid and hold off until every outstanding result is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Receiver. One decision per edge: a long hold-off when asked for,
   // otherwise a random stall after each ready cycle.
   // ---------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            stall_left      = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: each result against the oldest pending expectation,
   // one half at a time.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      pending_result_type want;
      if (reset !== 1'b1 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_error($sformatf("result with nothing pending: %h_%h",
                  rsp_result_high, rsp_result_low));
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_low !== want.value[HALF_W-1:0])
               report_error($sformatf("word %0d result_low %h, expected %h", want.seq,
                     rsp_result_low, want.value[HALF_W-1:0]));
            if (rsp_result_high !== want.value[VEC_W-1:HALF_W])
               report_error($sformatf("word %0d result_high %h, expected %h", want.seq,
                     rsp_result_high, want.value[VEC_W-1:HALF_W]));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      vec_word_type w;

      // Hold every input at a known value from time zero.
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_action <= ACT_BUILD;
      req_a_low  <= '0;
      req_a_high <= '0;
      req_b_low  <= '0;
      req_b_high <= '0;
      req_c_low  <= '0;
      req_c_high <= '0;
      req_scalar <= '0;

      // Directed words. Answers are typed in where they are obvious at a
      // glance; the rest go through the predictor.
      add_row(ACT_BUILD, 128'h807F0001FFFE40C0817E02FD10F055AA, '1, '0, 8'h00,
            1'b1, 128'h807F0001FFFE40C0817E02FD10F055AA);
      add_row(ACT_SPLAT, '0, '0, '0, 8'h80, 1'b1, {16{8'h80}});
      // Negating the most negative lane wraps back onto itself.
      add_row(ACT_NEG, {16{8'h80}}, '0, '0, 8'h00, 1'b1, {16{8'h80}});
      add_row(ACT_ADD, {16{8'h7F}}, {16{8'h01}}, '0, 8'h00, 1'b1, {16{8'h80}});
      add_row(ACT_SUB, 128'h807F0001FFFE40C0817E02FD10F055AA,
            128'h7F8000FF01FEC040817F03FDF010AA55, '0, 8'h00, 1'b0, '0);
      add_row(ACT_MUL, {16{8'h10}}, {16{8'h10}}, '1, 8'h00, 1'b1, '0);
      add_row(ACT_ADDSAT, {16{8'h7F}}, {16{8'h7F}}, '0, 8'h00, 1'b1, {16{8'h7F}});
      add_row(ACT_ADDSAT, {16{8'h80}}, {16{8'h80}}, '0, 8'h00, 1'b1, {16{8'h80}});
      // Saturating difference, not a sum: 127 - (-128) clamps high,
      // -128 - (-128) is exactly zero, -128 - 1 clamps low.
      add_row(ACT_SUBSAT, {16{8'h7F}}, {16{8'h80}}, '0, 8'h00, 1'b1, {16{8'h7F}});
      add_row(ACT_SUBSAT, {16{8'h80}}, {16{8'h80}}, '0, 8'h00, 1'b1, '0);
      add_row(ACT_SUBSAT, {16{8'h80}}, {16{8'h01}}, '0, 8'h00, 1'b1, {16{8'h80}});
      add_row(ACT_MIN, {16{8'h80}}, {16{8'h7F}}, '0, 8'h00, 1'b1, {16{8'h80}});
      add_row(ACT_MAX, {16{8'h80}}, {16{8'h7F}}, '0, 8'h00, 1'b1, {16{8'h7F}});
      // Mixed lanes, some equal, for the compare family.
      for (int op = int'(ACT_LT); op <= int'(ACT_GE); op++)
         add_row(5'(op), 128'h807F0001FFFE40C0817E02FD10F055AA,
               128'h7F8000FF01FEC040817F03FDF010AA55, '0, 8'h00, 1'b0, '0);
      // Out-of-range counts act as a full-lane shift.
      add_row(ACT_SHL, {16{8'hFF}}, '0, '0, 8'hFF, 1'b1, '0);
      add_row(ACT_SHR, {{8{8'h80}}, {8{8'h7F}}}, '0, '0, 8'h7F, 1'b1,
            {{8{8'hFF}}, {8{8'h00}}});
      add_row(ACT_SHR, 128'h807F0001FFFE40C0817E02FD10F055AA, '0, '0, 8'h00, 1'b1,
            128'h807F0001FFFE40C0817E02FD10F055AA);
      // Only 0x01 selects the true lane; 0xFF and 0x02 must not.
      add_row(ACT_SELECT, 128'h01FF0002010180_7F0100FE010301FF01,
            128'hA1A2A3A4A5A6A7A8A9AAABACADAEAFB0,
            128'h0F1E2D3C4B5A69788796A5B4C3D2E1F0, 8'h00, 1'b0, '0);
      add_row(ACT_UNKNOWN_LAST, '1, '1, '1, 8'h7F, 1'b1, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) offer(directed_rows[i]);
      drain_results();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // Back the pipe up: the receiver goes quiet while words keep coming.
         if (n == 300) rsp_hold_cycles = LONG_HOLD;
         // A stretch with no idling on either side.
         calm_mode = (n >= 800 && n < 1000);
         w = random_word();
         offer(w);
         if (n == 650) drain_results();
      end

      drain_results();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Guard against a hang: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> simd_int8x16_alu_top.f
rtl/core/simd8x16_pkg.sv
rtl/core/simd_int8x16_alu_top.sv
rtl/core/simd8x16_chk.sv
tb/sv/simd_int8x16_alu_top_test.sv
